// ===== rtl/core/zvc_pkg.sv =====
// ----------------------------------------------------------------------------
// zvc_pkg: shared types, constants and helpers of the zigzag VLQ codec
// Register indexes, result kinds, group geometry and the zigzag mapping.
// ----------------------------------------------------------------------------
package zvc_pkg;

    // Value and byte geometry
    localparam int VALUE_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int GROUP_W  = 7;
    localparam int COUNT_W  = 3;
    localparam int GCOUNT_W = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIRECTION   = 1'b0,
        REG_SIGNED_MODE = 1'b1
    } cfg_reg_t;

    // Direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // Byte count codes held in the work register
    localparam logic [COUNT_W-1:0] CNT_ONE   = 3'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO   = 3'd2;
    localparam logic [COUNT_W-1:0] CNT_THREE = 3'd3;
    localparam logic [COUNT_W-1:0] CNT_FOUR  = 3'd4;
    localparam logic [COUNT_W-1:0] CNT_FIVE  = 3'd5;

    // Saturation point of the decode group counter
    localparam logic [GCOUNT_W-1:0] GCOUNT_MAX = 3'd7;

    // Decoder result handed to the top level
    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   value;
        logic                 overflow;
    } dec_result_t;

    // Zigzag map: sign goes to bit 0
    function automatic logic [VALUE_W-1:0] zig(input logic [VALUE_W-1:0] v);
        return {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
    endfunction

    // Inverse zigzag map
    function automatic logic [VALUE_W-1:0] unzig(input logic [VALUE_W-1:0] z);
        return {1'b0, z[VALUE_W-1:1]} ^ {VALUE_W{z[0]}};
    endfunction

    // Number of 7-bit groups needed for a value, 1 to 5
    function automatic logic [COUNT_W-1:0] group_count(input logic [VALUE_W-1:0] v);
        logic [COUNT_W-1:0] n;
        if (v[31:28] != '0)
            n = CNT_FIVE;
        else if (v[27:21] != '0)
            n = CNT_FOUR;
        else if (v[20:14] != '0)
            n = CNT_THREE;
        else if (v[13:7] != '0)
            n = CNT_TWO;
        else
            n = CNT_ONE;
        return n;
    endfunction

endpackage

// ===== rtl/core/zvc_if.sv =====
// ----------------------------------------------------------------------------
// zvc_if: word channels of the zigzag VLQ codec
// Input channel carries a value or a byte; output channel carries one result.
// ----------------------------------------------------------------------------
interface zvc_in_if;
    logic                        valid;
    logic                        ready;
    logic [zvc_pkg::VALUE_W-1:0] in_value;
    logic [zvc_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_value, output in_byte, input ready);
    modport sink   (input valid, input in_value, input in_byte, output ready);
endinterface

interface zvc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        out_kind;
    logic [zvc_pkg::BYTE_W-1:0]  out_byte;
    logic [zvc_pkg::VALUE_W-1:0] out_value;
    logic                        last;
    logic                        overflow;

    modport source (output valid, output out_kind, output out_byte, output out_value,
                    output last, output overflow, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_value,
                    input last, input overflow, output ready);
endinterface

// ===== rtl/core/zvc_decoder.sv =====
// ----------------------------------------------------------------------------
// zvc_decoder: run accumulator of the VLQ decoder
// Gathers 7-bit groups per accepted byte, flags lost bits, and presents the
// finished value in the cycle the ending byte is accepted.
// ----------------------------------------------------------------------------
module zvc_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [zvc_pkg::BYTE_W-1:0]  byte_in,
    input  logic                        signed_mode,
    output zvc_pkg::dec_result_t        result
);

    logic [zvc_pkg::VALUE_W-1:0]  acc_reg;
    logic [zvc_pkg::VALUE_W-1:0]  acc_next;
    logic [zvc_pkg::GCOUNT_W-1:0] gcount_reg;
    logic [zvc_pkg::GCOUNT_W-1:0] gcount_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic                         ends;

    // Shift in the new group; bits leaving the top set overflow
    always_comb
    begin
        acc_next    = {acc_reg[zvc_pkg::VALUE_W-zvc_pkg::GROUP_W-1:0],
                       byte_in[zvc_pkg::GROUP_W-1:0]};
        ovf_next    = ovf_reg | (acc_reg[zvc_pkg::VALUE_W-1:zvc_pkg::VALUE_W-zvc_pkg::GROUP_W]
                                 != '0);
        gcount_next = (gcount_reg < zvc_pkg::GCOUNT_MAX) ? gcount_reg + 3'd1 : gcount_reg;
        ends        = ~byte_in[zvc_pkg::BYTE_W-1];
    end

    // Finished value: zero on overflow, else unmapped in signed mode
    always_comb
    begin
        result.done     = step & ends;
        result.overflow = ovf_next;
        if (ovf_next)
            result.value = '0;
        else if (signed_mode)
            result.value = zvc_pkg::unzig(acc_next);
        else
            result.value = acc_next;
    end

    // Run state: cleared when a run ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            gcount_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (ends)
            begin
                acc_reg    <= '0;
                gcount_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                acc_reg    <= acc_next;
                gcount_reg <= gcount_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // An empty group counter means a fresh run: nothing gathered yet
    a_fresh_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (gcount_reg == '0) |-> (acc_reg == '0 && !ovf_reg))
        else $error("decoder state not clear at run start");

    // Overflow can only be flagged once more than four groups were taken
    a_ovf_late: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (gcount_reg > zvc_pkg::CNT_FOUR))
        else $error("decoder overflow flagged too early");

    // A continuation byte never finishes a value
    a_cont_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && byte_in[zvc_pkg::BYTE_W-1]) |-> !result.done)
        else $error("continuation byte ended a run");
`endif

endmodule

// ===== rtl/core/zigzag_vlq_codec.sv =====
// ----------------------------------------------------------------------------
// zigzag_vlq_codec: 32-bit zigzag base-128 VLQ encoder and decoder
// Converts values to big-endian 7-bit-group bytes, or bytes back to values.
// ----------------------------------------------------------------------------
// Usage:
//   feed   - input words: in_value when encoding, in_byte when decoding.
//   result - output words: one byte per word when encoding (last marks the
//            final byte of a run), one value per word when decoding.
//   cfg_*  - write port: index 0 direction, index 1 signed_mode. Write only
//            while the block is idle.
// Path: a result word passes the work register, then the output register.
// Throughput: decoding takes one byte per cycle unless the output stalls.
//   Encoding sends 1..5 bytes of each value through the single output
//   byte lane; the next value is taken in the cycle the last byte leaves
//   the work register.
// Reset: direction = encode, signed_mode = 1, decode run cleared, both
//   pipeline registers empty.
// Stall: when result.ready is low the output register holds its word and
//   the work register holds; feed.ready drops until space frees up.
// ----------------------------------------------------------------------------
module zigzag_vlq_codec (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [zvc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [zvc_pkg::CFG_DATA_W-1:0]  cfg_data,
    zvc_in_if.sink                          feed,
    zvc_out_if.source                       result
);

    // Configuration registers
    logic direction_reg;
    logic signed_mode_reg;

    // Work register: one pending result sequence
    logic                        work_valid_reg;
    logic                        work_kind_reg;
    logic [zvc_pkg::VALUE_W-1:0] work_value_reg;
    logic [zvc_pkg::COUNT_W-1:0] work_cnt_reg;
    logic                        work_ovf_reg;

    // Output register
    logic                        out_valid_reg;
    logic                        out_kind_reg;
    logic [zvc_pkg::BYTE_W-1:0]  out_byte_reg;
    logic [zvc_pkg::VALUE_W-1:0] out_value_reg;
    logic                        out_last_reg;
    logic                        out_ovf_reg;

    logic                        out_free;
    logic                        emit;
    logic                        work_final;
    logic                        accept;
    logic                        dec_step;
    logic [zvc_pkg::VALUE_W-1:0] enc_value;
    logic [zvc_pkg::GROUP_W-1:0] group;
    zvc_pkg::dec_result_t        dec_res;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= zvc_pkg::DIR_ENCODE;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (zvc_pkg::cfg_reg_t'(cfg_index))
                zvc_pkg::REG_DIRECTION:   direction_reg   <= cfg_data[0];
                zvc_pkg::REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    // Handshake
    assign out_free   = !out_valid_reg || result.ready;
    assign emit       = work_valid_reg && out_free;
    assign work_final = (work_cnt_reg == zvc_pkg::CNT_ONE);
    assign feed.ready = !work_valid_reg || (out_free && work_final);
    assign accept     = feed.valid && feed.ready;
    assign dec_step   = accept && (direction_reg == zvc_pkg::DIR_DECODE);

    assign enc_value = signed_mode_reg ? zvc_pkg::zig(feed.in_value) : feed.in_value;

    zvc_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (dec_step),
        .byte_in     (feed.in_byte),
        .signed_mode (signed_mode_reg),
        .result      (dec_res)
    );

    // Work register: load on an encode accept or a finished decode, count down per emitted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            work_cnt_reg   <= '0;
        end
        else if (accept && direction_reg == zvc_pkg::DIR_ENCODE)
        begin
            work_valid_reg <= 1'b1;
            work_cnt_reg   <= zvc_pkg::group_count(enc_value);
        end
        else if (dec_step && dec_res.done)
        begin
            work_valid_reg <= 1'b1;
            work_cnt_reg   <= zvc_pkg::CNT_ONE;
        end
        else if (emit)
        begin
            if (work_final)
                work_valid_reg <= 1'b0;
            work_cnt_reg <= work_cnt_reg - 3'd1;
        end
    end

    // Work payload
    always_ff @(posedge clk)
    begin
        if (accept && direction_reg == zvc_pkg::DIR_ENCODE)
        begin
            work_kind_reg  <= zvc_pkg::KIND_BYTE;
            work_value_reg <= enc_value;
            work_ovf_reg   <= 1'b0;
        end
        else if (dec_step && dec_res.done)
        begin
            work_kind_reg  <= zvc_pkg::KIND_VALUE;
            work_value_reg <= dec_res.value;
            work_ovf_reg   <= dec_res.overflow;
        end
    end

    // Select the group for the current byte, most significant first
    always_comb
    begin
        unique case (work_cnt_reg)
            zvc_pkg::CNT_ONE:   group = work_value_reg[6:0];
            zvc_pkg::CNT_TWO:   group = work_value_reg[13:7];
            zvc_pkg::CNT_THREE: group = work_value_reg[20:14];
            zvc_pkg::CNT_FOUR:  group = work_value_reg[27:21];
            zvc_pkg::CNT_FIVE:  group = {3'b000, work_value_reg[31:28]};
            default:            group = '0;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= work_kind_reg;
            if (work_kind_reg == zvc_pkg::KIND_BYTE)
            begin
                out_byte_reg  <= {~work_final, group};
                out_value_reg <= '0;
                out_last_reg  <= work_final;
                out_ovf_reg   <= 1'b0;
            end
            else
            begin
                out_byte_reg  <= '0;
                out_value_reg <= work_value_reg;
                out_last_reg  <= 1'b0;
                out_ovf_reg   <= work_ovf_reg;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_kind  = out_kind_reg;
    assign result.out_byte  = out_byte_reg;
    assign result.out_value = out_value_reg;
    assign result.last      = out_last_reg;
    assign result.overflow  = out_ovf_reg;

`ifndef ASSERT_OFF
    // A pending sequence always has bytes left
    a_work_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        work_valid_reg |-> (work_cnt_reg != '0 && work_cnt_reg <= zvc_pkg::CNT_FIVE))
        else $error("work register valid with bad byte count");

    // Decoded results carry a single word
    a_value_single: assert property (@(posedge clk) disable iff (!rst_n)
        (work_valid_reg && work_kind_reg == zvc_pkg::KIND_VALUE) |-> work_final)
        else $error("decoded result spans several words");

    // An overflowed decode reports value zero
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.overflow) |-> (result.out_value == '0))
        else $error("overflow result with nonzero value");

    // A byte with the continuation bit clear ends the encoded run
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.out_kind == zvc_pkg::KIND_BYTE)
            |-> (result.last == !result.out_byte[zvc_pkg::BYTE_W-1]))
        else $error("last flag disagrees with continuation bit");

    // A stalled work register keeps its byte position
    a_work_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (work_valid_reg && !out_free) |=> $stable(work_cnt_reg))
        else $error("work register advanced under stall");
`endif

endmodule
